/* hdl/acs_pkg.sv */
// shared types, codes and constants of the adc channel scan sequencer
package acs_pkg;

  // channel capacity of the sequencer (channel field is 4 bits wide)
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned ChanFieldCap = 16;
  localparam int unsigned ChanCap =
    (MaxChannels < ChanFieldCap) ? MaxChannels : ChanFieldCap;

  // configuration register indexes
  localparam logic [2:0] CfgChannelCount = 3'd0;
  localparam logic [2:0] CfgSettleTicks  = 3'd1;
  localparam logic [2:0] CfgPollLimit    = 3'd2;
  localparam logic [2:0] CfgAcrEnable    = 3'd3;
  localparam logic [2:0] CfgAcrChannel   = 3'd4;

  // configuration reset values
  localparam logic [4:0] RstChannelCount = 5'd16;
  localparam logic [7:0] RstSettleTicks  = 8'd8;
  localparam logic [7:0] RstPollLimit    = 8'hFF;

  // stream word widths
  localparam int unsigned InDataW  = 72;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 5;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdLock    = 2'd1,
    CmdTrigger = 2'd2,
    CmdRenew   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StOpen    = 3'd1,
    StOpening = 3'd2,
    StTrigger = 3'd3,
    StReadI   = 3'd4,
    StReadV   = 3'd5,
    StClose   = 3'd6,
    StHalt    = 3'd7
  } seq_state_e;

  typedef enum logic [2:0] {
    ActNone     = 3'd0,
    ActDeselect = 3'd1,
    ActOpen     = 3'd2,
    ActTrigger  = 3'd3,
    ActReadI    = 3'd4,
    ActReadV    = 3'd5,
    ActReinit   = 3'd6
  } action_e;

  typedef struct packed {
    logic [4:0] channel_count;
    logic [7:0] settle_ticks;
    logic [7:0] poll_limit;
    logic       acr_enable;
    logic [3:0] acr_channel;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  ir_channel;
    logic        ready_current;
    logic        ready_voltage;
    logic [31:0] current_word;
    logic [31:0] voltage_word;
  } item_t;

  typedef struct packed {
    action_e     action;
    logic [3:0]  channel;
    logic        store_current;
    logic        store_voltage;
    logic [31:0] sample_value;
    logic        acr_drive;
    logic [2:0]  phase;
  } result_t;

endpackage

/* hdl/acs_cfg_regs.sv */
// configuration register file of the scan sequencer
module acs_cfg_regs import acs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgChannelCount: cfg_d.channel_count = cfg_data_i[4:0];
        CfgSettleTicks:  cfg_d.settle_ticks  = cfg_data_i;
        CfgPollLimit:    cfg_d.poll_limit    = cfg_data_i;
        CfgAcrEnable:    cfg_d.acr_enable    = cfg_data_i[0];
        CfgAcrChannel:   cfg_d.acr_channel   = cfg_data_i[3:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count <= RstChannelCount;
      cfg_q.settle_ticks  <= RstSettleTicks;
      cfg_q.poll_limit    <= RstPollLimit;
      cfg_q.acr_enable    <= 1'b0;
      cfg_q.acr_channel   <= 4'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/acs_seq_core.sv */
// sequencer state registers and one-step next-state logic
module acs_seq_core import acs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_en_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  localparam logic [4:0] ChanCapW = 5'(ChanCap);

  seq_state_e state_q, state_d;
  logic [3:0] scan_q, scan_d;
  logic [7:0] settle_q, settle_d;
  logic [8:0] poll_q, poll_d;
  logic [3:0] lock_ch_q, lock_ch_d;
  logic [3:0] saved_q, saved_d;
  logic       lock_act_q, lock_act_d;
  logic       lock_sw_q, lock_sw_d;
  logic       mux_rdy_q, mux_rdy_d;

  logic [4:0] wrap_bound;
  logic [4:0] next_chan;
  logic [7:0] settle_inc;
  logic [8:0] poll_inc;
  logic       poll_exhausted;
  logic       ready_sel;
  logic       keep_chan;
  result_t    res;

  // wrap point of the scan and shared counter arithmetic
  assign wrap_bound     = (cfg_i.channel_count > ChanCapW) ? ChanCapW : cfg_i.channel_count;
  assign next_chan      = {1'b0, scan_q} + 5'd1;
  assign settle_inc     = settle_q + 8'd1;
  assign poll_inc       = poll_q + 9'd1;
  assign poll_exhausted = poll_q >= {1'b0, cfg_i.poll_limit};
  assign ready_sel      = (state_q == StReadI) ? item_i.ready_current : item_i.ready_voltage;

  // next state of one word
  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    settle_d   = settle_q;
    poll_d     = poll_q;
    lock_ch_d  = lock_ch_q;
    saved_d    = saved_q;
    lock_act_d = lock_act_q;
    lock_sw_d  = lock_sw_q;
    mux_rdy_d  = mux_rdy_q;

    unique case (item_i.cmd)
      CmdLock: begin
        saved_d    = scan_q;
        lock_ch_d  = item_i.ir_channel;
        lock_act_d = 1'b1;
        mux_rdy_d  = 1'b0;
      end
      CmdTrigger: begin
        state_d = StTrigger;
      end
      CmdRenew: begin
        scan_d     = saved_q;
        lock_act_d = 1'b0;
        lock_sw_d  = 1'b0;
        state_d    = StIdle;
      end
      CmdTick: begin
        unique case (state_q)
          StIdle: begin
            state_d  = StOpen;
            settle_d = 8'd0;
            scan_d   = 4'd0;
          end
          StOpen: begin
            settle_d = 8'd0;
            state_d  = StOpening;
            if (lock_act_q) begin
              lock_sw_d = 1'b1;
              scan_d    = lock_ch_q;
            end
          end
          StOpening: begin
            settle_d = settle_inc;
            if (settle_inc >= cfg_i.settle_ticks) begin
              state_d  = (lock_act_q && lock_sw_q) ? StHalt : StTrigger;
              settle_d = 8'd0;
            end
          end
          StTrigger: begin
            poll_d  = 9'd0;
            state_d = StReadI;
          end
          StReadI, StReadV: begin
            if (ready_sel) begin
              state_d = (state_q == StReadI) ? StReadV : StClose;
            end else begin
              poll_d = poll_inc;
              // too many failed polls: restart the scan
              if (poll_exhausted) begin
                state_d    = StIdle;
                scan_d     = 4'd0;
                saved_d    = 4'd0;
                lock_act_d = 1'b0;
                lock_sw_d  = 1'b0;
              end
            end
          end
          StClose: begin
            if (!lock_act_q) begin
              scan_d  = (next_chan >= wrap_bound) ? 4'd0 : next_chan[3:0];
              state_d = StOpen;
            end else if (mux_rdy_q) begin
              state_d = StHalt;
            end else begin
              scan_d  = lock_ch_q;
              state_d = StOpen;
            end
          end
          StHalt: begin
            mux_rdy_d = 1'b1;
          end
          default: begin
            state_d = state_q;
          end
        endcase
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  // result of one word
  always_comb begin
    res        = '0;
    res.action = ActNone;
    keep_chan  = 1'b0;
    if (item_i.cmd == CmdTick) begin
      unique case (state_q)
        StIdle: begin
          res.action = ActDeselect;
        end
        StOpen: begin
          res.action    = ActOpen;
          res.acr_drive = cfg_i.acr_enable && (cfg_i.acr_channel == scan_d);
        end
        StTrigger: begin
          res.action = ActTrigger;
        end
        StReadI: begin
          if (item_i.ready_current) begin
            res.action        = ActReadI;
            res.sample_value  = item_i.current_word;
            res.store_current = item_i.current_word != 32'd0;
          end else if (poll_exhausted) begin
            // reinit is reported on the old channel
            res.action = ActReinit;
            keep_chan  = 1'b1;
          end
        end
        StReadV: begin
          if (item_i.ready_voltage) begin
            res.action        = ActReadV;
            res.sample_value  = item_i.voltage_word;
            res.store_voltage = item_i.voltage_word != 32'd0;
          end else if (poll_exhausted) begin
            res.action = ActReinit;
            keep_chan  = 1'b1;
          end
        end
        default: begin
          res.action = ActNone;
        end
      endcase
    end
    res.channel = keep_chan ? scan_q : scan_d;
    res.phase   = state_d;
  end

  assign result_o = res;

  // state update once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      scan_q     <= 4'd0;
      settle_q   <= 8'd0;
      poll_q     <= 9'd0;
      lock_ch_q  <= 4'd0;
      saved_q    <= 4'd0;
      lock_act_q <= 1'b0;
      lock_sw_q  <= 1'b0;
      mux_rdy_q  <= 1'b0;
    end else if (step_en_i) begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      settle_q   <= settle_d;
      poll_q     <= poll_d;
      lock_ch_q  <= lock_ch_d;
      saved_q    <= saved_d;
      lock_act_q <= lock_act_d;
      lock_sw_q  <= lock_sw_d;
      mux_rdy_q  <= mux_rdy_d;
    end
  end

endmodule

/* hdl/adc_channel_scan_sequencer.sv */
// top level of the adc channel scan sequencer with stream ports
//
// Each word on the slave stream is one timer tick or command for a scan
// sequencer that drives paired current and voltage converters behind an
// analog mux. Every word produces exactly one result word on the master
// stream: the action to perform (deselect, open mux, trigger, read,
// reinit), the channel concerned, the sample read and status flags.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while no word is in flight.
// A word lands in the input register, then the one-step sequencer logic
// loads its result into the result register when that register is empty or
// its result is being taken.
// Throughput is one word per cycle while results are taken; the result and
// input registers form a two-deep pipe, so a new word is taken while a
// result waits. When the receiver stalls, the result holds, the input
// register fills, and then s_axis_tready_o drops until the result is taken.
// Reset clears the pipe, puts the sequencer in idle on channel 0 with no
// channel lock, and loads the default configuration.
module adc_channel_scan_sequencer import acs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // ir_channel[3:0], ready_current[4], ready_voltage[5],
  // current_word[37:6], voltage_word[69:38], zero fill [71:70]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  // master stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // channel[3:0], sample_value[35:4], acr_drive[36], phase[39:37]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // action[2:0], store_current[3], store_voltage[4]
  output logic [OutUserW-1:0] m_axis_tuser_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q, in_d;
  logic    in_valid_q, in_valid_d;
  result_t out_q;
  result_t step_res;
  logic    out_valid_q, out_valid_d;
  logic    advance;
  logic    in_take;

  // configuration registers
  acs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // pipe control
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // unpack the incoming word
  always_comb begin
    in_d               = in_q;
    if (in_take) begin
      in_d.cmd           = cmd_e'(s_axis_tuser_i[1:0]);
      in_d.ir_channel    = s_axis_tdata_i[3:0];
      in_d.ready_current = s_axis_tdata_i[4];
      in_d.ready_voltage = s_axis_tdata_i[5];
      in_d.current_word  = s_axis_tdata_i[37:6];
      in_d.voltage_word  = s_axis_tdata_i[69:38];
    end
  end

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !m_axis_tready_i);

  // sequencer step
  acs_seq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (step_res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q <= in_d;
    if (advance) begin
      out_q <= step_res;
    end
  end

  // pack the result word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.phase, out_q.acr_drive, out_q.sample_value, out_q.channel};
  assign m_axis_tuser_o  = {out_q.store_voltage, out_q.store_current, out_q.action};

  // store flags only come with the matching read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.store_current || out_q.store_voltage) |->
      (out_q.store_current && out_q.action == ActReadI) ||
      (out_q.store_voltage && out_q.action == ActReadV))
    else $error("store flag without matching read action");

  // drive pulse only when the mux opens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.acr_drive |-> out_q.action == ActOpen)
    else $error("acr drive outside of mux open");

  // sample value is zero unless a converter was read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.action != ActReadI && out_q.action != ActReadV |->
      out_q.sample_value == 32'd0)
    else $error("nonzero sample without read");

  // a buffered word is never dropped while waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("buffered input word lost");

endmodule
